// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the owner pass-through core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// ----- rtl/tpo_pkg.sv -----
// Package with the types and constants of the owner pass-through core.
`default_nettype none
package tpo_pkg;

    localparam int OWN_W  = 7;
    localparam int MEMO_W = 7;

    localparam logic [OWN_W-1:0]  OWN_ABSENT       = 7'd64;
    localparam logic [MEMO_W-1:0] CODE_NONE        = 7'd64;
    localparam logic [MEMO_W-1:0] CODE_IN_PROGRESS = 7'd66;

    typedef struct packed {
        logic [5:0] owner_index;
        logic       owner_present;
        logic       is_transparent;
        logic       last_node;
    } in_item_t;

    typedef struct packed {
        logic [5:0] node_number;
        logic [5:0] effective_owner;
        logic       effective_present;
        logic       last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_NODE,
        S_MEMO,
        S_OWN,
        S_HOP,
        S_PACK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic node_rd;
        logic hop_rd;
        logic ans_none;
        logic ans_own;
        logic ans_memo;
        logic push;
        logic pack;
        logic emit;
        logic next_node;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic load_end;
        logic any_trans;
        logic memo_hit;
        logic memo_unvisited;
        logic memo_inprog;
        logic own_out;
        logic trans_hit;
        logic depth_full;
        logic pack_busy;
        logic out_free;
        logic last_node;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/tpo_dpath.sv -----
// Datapath of the owner pass-through core: node tables, memo, walk stack and output register.
`default_nettype none
`include "assert_macros.svh"
module tpo_dpath #(
    parameter int MAX_NODES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tpo_pkg::in_item_t  in_item,
    input  wire tpo_pkg::cmd_t      cmd,
    output tpo_pkg::sts_t           sts,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output tpo_pkg::out_item_t      out_item
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [tpo_pkg::OWN_W-1:0]  owner_mem_reg [MAX_NODES];
    logic                       trans_mem_reg [MAX_NODES];
    logic [tpo_pkg::MEMO_W-1:0] memo_mem_reg  [MAX_NODES];
    logic [IW-1:0]              stack_mem_reg [MAX_NODES];

    logic [tpo_pkg::OWN_W-1:0]  own_rd_reg;
    logic                       trans_rd_reg;
    logic [tpo_pkg::MEMO_W-1:0] memo_rd_reg;
    logic                       memo_rd_vld_reg;
    logic [IW-1:0]              stack_rd_reg;
    logic [tpo_pkg::MEMO_W-1:0] ans_reg, ans_next;
    tpo_pkg::out_item_t         out_item_reg, out_item_next;

    logic [MAX_NODES-1:0] memo_vld_reg, memo_vld_next;
    logic [CW-1:0]        node_count_reg, node_count_next;
    logic                 any_trans_reg, any_trans_next;
    logic [IW-1:0]        node_idx_reg, node_idx_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;

    logic [IW-1:0]              load_idx;
    logic [tpo_pkg::OWN_W-1:0]  load_word;
    logic [IW-1:0]              own_addr;
    logic                       own_rd_en;
    logic [IW-1:0]              own_rd_addr;
    logic                       memo_rd_en;
    logic [IW-1:0]              memo_rd_addr;
    logic                       memo_we;
    logic [IW-1:0]              memo_waddr;
    logic [tpo_pkg::MEMO_W-1:0] memo_wdata;
    logic [CW-1:0]              depth_dec;
    logic                       pop;
    logic                       is_last;
    logic                       echo_present;

    assign load_idx  = node_count_reg[IW-1:0];
    assign load_word = in_item.owner_present ? {1'b0, in_item.owner_index}
                                             : tpo_pkg::OWN_ABSENT;
    assign own_addr  = own_rd_reg[IW-1:0];
    assign depth_dec = depth_reg - CW'(1);
    assign pop       = cmd.pack && (depth_reg != '0);
    assign is_last   = (CW'(node_idx_reg) + CW'(1)) == node_count_reg;

    assign own_rd_en    = cmd.node_rd || cmd.push;
    assign own_rd_addr  = cmd.node_rd ? node_idx_reg : own_addr;
    assign memo_rd_en   = cmd.node_rd || cmd.hop_rd;
    assign memo_rd_addr = cmd.node_rd ? node_idx_reg : own_addr;

    always_comb
    begin
        memo_we    = 1'b0;
        memo_waddr = node_idx_reg;
        memo_wdata = ans_reg;
        if (cmd.push)
        begin
            memo_we    = 1'b1;
            memo_waddr = own_addr;
            memo_wdata = tpo_pkg::CODE_IN_PROGRESS;
        end
        else if (pend_reg)
        begin
            memo_we    = 1'b1;
            memo_waddr = stack_rd_reg;
        end
        else if (cmd.emit && any_trans_reg)
        begin
            memo_we = 1'b1;
        end
    end

    // Node tables, memo, walk stack and the answer and output data registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            owner_mem_reg[load_idx] <= load_word;
            trans_mem_reg[load_idx] <= in_item.is_transparent;
        end
        if (own_rd_en)
        begin
            own_rd_reg <= owner_mem_reg[own_rd_addr];
        end
        if (cmd.hop_rd)
        begin
            trans_rd_reg <= trans_mem_reg[own_addr];
        end
        if (memo_we)
        begin
            memo_mem_reg[memo_waddr] <= memo_wdata;
        end
        if (memo_rd_en)
        begin
            memo_rd_reg     <= memo_mem_reg[memo_rd_addr];
            memo_rd_vld_reg <= memo_vld_reg[memo_rd_addr];
        end
        if (cmd.push)
        begin
            stack_mem_reg[depth_reg[IW-1:0]] <= own_addr;
        end
        if (pop)
        begin
            stack_rd_reg <= stack_mem_reg[depth_dec[IW-1:0]];
        end
        ans_reg      <= ans_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        ans_next        = ans_reg;
        memo_vld_next   = memo_vld_reg;
        node_count_next = node_count_reg;
        any_trans_next  = any_trans_reg;
        node_idx_next   = node_idx_reg;
        depth_next      = depth_reg;
        pend_next       = pop;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        echo_present    = !own_rd_reg[tpo_pkg::OWN_W-1];

        if (cmd.ans_none)
        begin
            ans_next = tpo_pkg::CODE_NONE;
        end
        else if (cmd.ans_own)
        begin
            ans_next = own_rd_reg;
        end
        else if (cmd.ans_memo)
        begin
            ans_next = memo_rd_reg;
        end

        if (cmd.load)
        begin
            node_count_next = node_count_reg + CW'(1);
            any_trans_next  = any_trans_reg | in_item.is_transparent;
        end

        if (cmd.push)
        begin
            depth_next = depth_reg + CW'(1);
        end
        else if (pop)
        begin
            depth_next = depth_dec;
        end

        if (memo_we)
        begin
            memo_vld_next[memo_waddr] = 1'b1;
        end

        if (cmd.next_node)
        begin
            node_idx_next = node_idx_reg + IW'(1);
        end

        if (cmd.emit)
        begin
            out_valid_next            = 1'b1;
            out_item_next.node_number = 6'(node_idx_reg);
            out_item_next.last_result = is_last;
            if (any_trans_reg)
            begin
                out_item_next.effective_owner   = ans_reg[5:0];
                out_item_next.effective_present = !ans_reg[tpo_pkg::MEMO_W-1];
            end
            else
            begin
                out_item_next.effective_owner   = echo_present ? own_rd_reg[5:0] : 6'd0;
                out_item_next.effective_present = echo_present;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // The end of a set returns the memo and the counters to their reset state.
        if (cmd.finish)
        begin
            memo_vld_next   = '0;
            node_count_next = '0;
            any_trans_next  = 1'b0;
            node_idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memo_vld_reg   <= '0;
            node_count_reg <= '0;
            any_trans_reg  <= 1'b0;
            node_idx_reg   <= '0;
            depth_reg      <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            memo_vld_reg   <= memo_vld_next;
            node_count_reg <= node_count_next;
            any_trans_reg  <= any_trans_next;
            node_idx_reg   <= node_idx_next;
            depth_reg      <= depth_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        sts.load_end       = in_item.last_node ||
                             (node_count_reg == CW'(MAX_NODES - 1));
        sts.any_trans      = any_trans_reg;
        sts.memo_hit       = memo_rd_vld_reg && (memo_rd_reg != tpo_pkg::CODE_IN_PROGRESS);
        sts.memo_unvisited = !memo_rd_vld_reg;
        sts.memo_inprog    = memo_rd_vld_reg && (memo_rd_reg == tpo_pkg::CODE_IN_PROGRESS);
        sts.own_out        = own_rd_reg[tpo_pkg::OWN_W-1] ||
                             (8'(own_rd_reg[5:0]) >= 8'(node_count_reg));
        sts.trans_hit      = trans_rd_reg;
        sts.depth_full     = depth_reg == CW'(MAX_NODES);
        sts.pack_busy      = (depth_reg != '0) || pend_reg;
        sts.out_free       = !out_valid_reg || out_ready;
        sts.last_node      = is_last;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `ASSERT_PROP(a_push_room, clk, rst_n, cmd.push |-> (depth_reg < CW'(MAX_NODES)), "walk stack overflow")
    `ASSERT_PROP(a_walk_clean, clk, rst_n, cmd.node_rd |-> (depth_reg == '0 && !pend_reg), "walk stack not empty at node start")
    `ASSERT_PROP(a_finish_clear, clk, rst_n, cmd.finish |=> (memo_vld_reg == '0 && node_count_reg == '0), "set state not cleared")

endmodule
`default_nettype wire

// ----- rtl/tpo_ctrl.sv -----
// Controller state machine of the owner pass-through core.
`default_nettype none
`include "assert_macros.svh"
module tpo_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tpo_pkg::sts_t  sts,
    output tpo_pkg::cmd_t       cmd
);

    tpo_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpo_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            tpo_pkg::S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.load_end)
                    begin
                        state_next = tpo_pkg::S_NODE;
                    end
                end
            end
            tpo_pkg::S_NODE:
            begin
                cmd.node_rd = 1'b1;
                state_next  = tpo_pkg::S_MEMO;
            end
            tpo_pkg::S_MEMO:
            begin
                if (!sts.any_trans)
                begin
                    state_next = tpo_pkg::S_EMIT;
                end
                else if (sts.memo_hit)
                begin
                    cmd.ans_memo = 1'b1;
                    state_next   = tpo_pkg::S_EMIT;
                end
                else
                begin
                    state_next = tpo_pkg::S_OWN;
                end
            end
            tpo_pkg::S_OWN:
            begin
                if (sts.own_out)
                begin
                    cmd.ans_none = 1'b1;
                    state_next   = tpo_pkg::S_PACK;
                end
                else
                begin
                    cmd.hop_rd = 1'b1;
                    state_next = tpo_pkg::S_HOP;
                end
            end
            tpo_pkg::S_HOP:
            begin
                state_next = tpo_pkg::S_PACK;
                if (!sts.trans_hit)
                begin
                    cmd.ans_own = 1'b1;
                end
                else if (sts.memo_inprog)
                begin
                    cmd.ans_none = 1'b1;
                end
                else if (!sts.memo_unvisited)
                begin
                    cmd.ans_memo = 1'b1;
                end
                else if (sts.depth_full)
                begin
                    cmd.ans_none = 1'b1;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = tpo_pkg::S_OWN;
                end
            end
            tpo_pkg::S_PACK:
            begin
                cmd.pack = 1'b1;
                if (!sts.pack_busy)
                begin
                    state_next = tpo_pkg::S_EMIT;
                end
            end
            tpo_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_node)
                    begin
                        cmd.finish = 1'b1;
                        state_next = tpo_pkg::S_LOAD;
                    end
                    else
                    begin
                        cmd.next_node = 1'b1;
                        state_next    = tpo_pkg::S_NODE;
                    end
                end
            end
            default:
            begin
                state_next = tpo_pkg::S_LOAD;
            end
        endcase
    end

    `ASSERT_PROP(a_emit_free, clk, rst_n, cmd.emit |-> sts.out_free, "result loaded into a full output register")
    `ASSERT_PROP(a_last_to_load, clk, rst_n, (cmd.emit && sts.last_node) |=> (state_reg == tpo_pkg::S_LOAD), "set did not end after last result")
    `ASSERT_NEVER(a_load_during_pack, clk, rst_n, in_ready && sts.pack_busy, "transaction taken during path compression")

endmodule
`default_nettype wire

// ----- rtl/transparent_owner_pass_through_core.sv -----
// Top level of the owner pass-through core: controller plus datapath.
//
// The input channel (in_valid, in_ready, in_item) loads one node per transaction. Node i of
// a set is the i-th transaction; the transaction with last_node set, or the MAX_NODES-th one,
// closes the set. Loading keeps in_ready high, so nodes may arrive back to back; it is refused while a set is resolved.
// The block then emits one transaction per node on the output channel (out_valid, out_ready,
// out_item), in node order, with last_result on the final one. Each result carries the
// nearest owner up the chain that is not transparent; a missing or out-of-range owner, or
// a loop through transparent owners, gives no owner. When no node in the set is transparent
// the owner fields are echoed.
// Per node the controller reads the tables (S_NODE), checks the memo (S_MEMO) and, for an echo
// or a memo hit, emits (S_EMIT). A node that needs a walk goes from S_MEMO to S_OWN and S_HOP,
// back to S_OWN for each transparent owner pushed on the walked path, then to S_PACK, which
// compresses that path, and then to S_EMIT.
// A hop is two registered reads: the transparent flag and memo, then the next owner.
// A stalled receiver holds the output register; the controller waits before loading the
// next result, so nothing is lost. Reset empties the set, marks every memo entry unvisited
// and drops any pending result; the tables need no clearing pass.
`default_nettype none
module transparent_owner_pass_through_core #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tpo_pkg::in_item_t   in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tpo_pkg::out_item_t       out_item
);

    // Commands from the controller and status back from the datapath.
    tpo_pkg::cmd_t cmd;
    tpo_pkg::sts_t sts;

    tpo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the node tables, the memo with its valid bits, the walk stack
    // and the output register that decouples the receiver from the walk.
    tpo_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the transparent owner pass-through core.
`timescale 1ns / 1ps

module testbench;

    // The testbench keeps its own model of the node tables. It uses the block's
    // default table size, so a set of 64 nodes fills the table.
    localparam int unsigned TB_MAX_NODES = 64;
    localparam int unsigned RANDOM_ITEMS = 310;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned IDLE_PCT     = 8;
    localparam int unsigned REPORT_MAX   = 10;

    // Memo codes, widened to the 8-bit memo entry of the predictor.
    localparam logic [7:0] MEMO_NONE        = {1'b0, tpo_pkg::CODE_NONE};
    localparam logic [7:0] MEMO_UNVISITED   = 8'd65;
    localparam logic [7:0] MEMO_IN_PROGRESS = {1'b0, tpo_pkg::CODE_IN_PROGRESS};

    // The scoreboard predicts the effective owner of every node of a set. It
    // mirrors the block's tables: a transaction on the input channel stores one
    // node, and the transaction that closes the set produces one expected
    // result per node, which the output monitor then checks in order.
    class owner_scoreboard;
        logic [6:0]          owner_tab [TB_MAX_NODES];
        bit                  trans_tab [TB_MAX_NODES];
        logic [7:0]          memo_tab  [TB_MAX_NODES];
        logic [5:0]          path_tab  [TB_MAX_NODES];
        int unsigned         node_cnt;
        bit                  any_trans;
        tpo_pkg::out_item_t  owner_results_q [$];
        int unsigned         mismatches;
        int unsigned         checked;
        int unsigned         sets_closed;
        int unsigned         full_sets;
        int unsigned         transparent_sets;

        function new();
            clear_set();
            mismatches       = 0;
            checked          = 0;
            sets_closed      = 0;
            full_sets        = 0;
            transparent_sets = 0;
        endfunction

        function void clear_set();
            node_cnt  = 0;
            any_trans = 1'b0;
            foreach (memo_tab[i])
                memo_tab[i] = MEMO_UNVISITED;
        endfunction

        // Walks up the owner chain from one node, skipping transparent owners,
        // and writes the answer back into the memo for every node walked.
        function logic [7:0] nearest_owner(int unsigned start, int unsigned n);
            int unsigned depth;
            int unsigned cur;
            int unsigned i;
            logic [7:0]  answer;
            logic [6:0]  own;
            logic [7:0]  m;
            depth  = 0;
            cur    = start;
            answer = MEMO_NONE;
            forever begin
                own = owner_tab[cur % TB_MAX_NODES];
                if (own[6] || own >= n)
                    break;
                if (!trans_tab[own]) begin
                    answer = {1'b0, own};
                    break;
                end
                m = memo_tab[own];
                if (m == MEMO_IN_PROGRESS)
                    break;
                if (m != MEMO_UNVISITED) begin
                    answer = m;
                    break;
                end
                if (depth >= TB_MAX_NODES)
                    break;
                memo_tab[own]   = MEMO_IN_PROGRESS;
                path_tab[depth] = own[5:0];
                depth++;
                cur = own;
            end
            for (i = 0; i < depth; i++)
                memo_tab[path_tab[i]] = answer;
            memo_tab[start % TB_MAX_NODES] = answer;
            return answer;
        endfunction

        function void note_node(tpo_pkg::in_item_t it);
            int unsigned         idx;
            int unsigned         n;
            int unsigned         i;
            logic [7:0]          m;
            logic [7:0]          r;
            tpo_pkg::out_item_t  res;
            idx = node_cnt % TB_MAX_NODES;
            owner_tab[idx] = it.owner_present ? {1'b0, it.owner_index} : tpo_pkg::OWN_ABSENT;
            trans_tab[idx] = it.is_transparent;
            any_trans      = any_trans | it.is_transparent;
            node_cnt       = idx + 1;
            if (!it.last_node && node_cnt < TB_MAX_NODES)
                return;
            n = node_cnt;
            if (n == TB_MAX_NODES)
                full_sets++;
            if (any_trans)
                transparent_sets++;
            for (i = 0; i < n; i++) begin
                res.node_number = i[5:0];
                res.last_result = (i + 1 == n);
                if (!any_trans) begin
                    // Nothing to skip: the owner fields are echoed as loaded.
                    res.effective_present = !owner_tab[i][6];
                    res.effective_owner   = owner_tab[i][6] ? 6'd0 : owner_tab[i][5:0];
                end else begin
                    m = memo_tab[i];
                    if (m == MEMO_UNVISITED || m == MEMO_IN_PROGRESS)
                        r = nearest_owner(i, n);
                    else
                        r = m;
                    res.effective_present = (r < 8'd64);
                    res.effective_owner   = (r < 8'd64) ? r[5:0] : 6'd0;
                end
                owner_results_q.push_back(res);
            end
            sets_closed++;
            clear_set();
        endfunction

        function void check_result(tpo_pkg::out_item_t got);
            tpo_pkg::out_item_t want;
            if (owner_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result node %0d owner %0d present %0b last %0b",
                             got.node_number, got.effective_owner, got.effective_present,
                             got.last_result);
                return;
            end
            want = owner_results_q.pop_front();
            checked++;
            if (got.node_number !== want.node_number
                || got.effective_owner !== want.effective_owner
                || got.effective_present !== want.effective_present
                || got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("ERROR: result %0d expected node %0d owner %0d present %0b last %0b",
                             checked, want.node_number, want.effective_owner,
                             want.effective_present, want.last_result);
                    $display("       got node %0d owner %0d present %0b last %0b",
                             got.node_number, got.effective_owner, got.effective_present,
                             got.last_result);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    tpo_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_ready;
    tpo_pkg::out_item_t out_item;

    owner_scoreboard sb;

    // When quiet is set, neither side idles; this gives one long stretch of
    // back-to-back transactions in the middle of the random part.
    bit          quiet;
    int unsigned node_total;
    int unsigned cycle_count;

    transparent_owner_pass_through_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // All signals are sampled in the active region right after the rising edge,
    // so they still hold the values from before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(out_item);
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // A run that hangs anywhere ends here.
    initial begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.owner_results_q.size());
        $display("FAILURE");
        $finish;
    end

    function automatic tpo_pkg::in_item_t make_node(logic [5:0] own, logic present,
                                                    logic transparent, logic last);
        tpo_pkg::in_item_t it;
        it.owner_index    = own;
        it.owner_present  = present;
        it.is_transparent = transparent;
        it.last_node      = last;
        return it;
    endfunction

    // Offers one node on the input channel, with a random gap before it, and
    // returns at the edge at which the transaction is accepted. The next call
    // either keeps valid high with a new payload or lowers it for a gap.
    task automatic send_node(input tpo_pkg::in_item_t it);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_node(it);
        node_total++;
    endtask

    // Sends one set of random nodes. Most owners point inside the set so that
    // the walks go deep; a few are arbitrary and often out of range.
    task automatic send_random_set(input int unsigned n, input bit close_flag);
        int unsigned       i;
        int unsigned       trans_pct;
        tpo_pkg::in_item_t it;
        trans_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70, 15);
        for (i = 0; i < n; i++) begin
            it.owner_present  = ($urandom_range(99) < 80);
            if ($urandom_range(99) < 85)
                it.owner_index = 6'($urandom_range(n - 1));
            else
                it.owner_index = 6'($urandom_range(63));
            it.is_transparent = ($urandom_range(99) < trans_pct);
            it.last_node      = (i == n - 1) ? close_flag : 1'b0;
            send_node(it);
        end
    endtask

    initial begin
        int unsigned set_no;
        int unsigned roll;
        int unsigned wait_cycles;
        sb          = new();
        quiet       = 1'b0;
        node_total  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No transparent node: owners are echoed, out of range or not, and an
        // absent owner reports zero whatever its index field holds.
        send_node(make_node(6'd63, 1'b1, 1'b0, 1'b0));
        send_node(make_node(6'd42, 1'b0, 1'b0, 1'b0));
        send_node(make_node(6'd0,  1'b1, 1'b0, 1'b1));

        // A single transparent node that owns itself is a loop.
        send_node(make_node(6'd0, 1'b1, 1'b1, 1'b1));

        // A chain through two transparent owners, a memo hit on the chain and
        // an owner just past the end of the set.
        send_node(make_node(6'd0, 1'b0, 1'b0, 1'b0));
        send_node(make_node(6'd0, 1'b1, 1'b1, 1'b0));
        send_node(make_node(6'd1, 1'b1, 1'b1, 1'b0));
        send_node(make_node(6'd2, 1'b1, 1'b0, 1'b0));
        send_node(make_node(6'd3, 1'b1, 1'b0, 1'b0));
        send_node(make_node(6'd2, 1'b1, 1'b0, 1'b0));
        send_node(make_node(6'd7, 1'b1, 1'b0, 1'b1));

        // A loop of three transparent nodes, entered from outside the loop.
        send_node(make_node(6'd1, 1'b1, 1'b1, 1'b0));
        send_node(make_node(6'd2, 1'b1, 1'b1, 1'b0));
        send_node(make_node(6'd0, 1'b1, 1'b1, 1'b0));
        send_node(make_node(6'd1, 1'b1, 1'b0, 1'b0));
        send_node(make_node(6'd3, 1'b1, 1'b0, 1'b1));

        // Transparent nodes whose own owner is out of range or absent.
        send_node(make_node(6'd60, 1'b1, 1'b1, 1'b0));
        send_node(make_node(6'd0,  1'b1, 1'b0, 1'b0));
        send_node(make_node(6'd63, 1'b0, 1'b1, 1'b0));
        send_node(make_node(6'd2,  1'b1, 1'b0, 1'b1));

        // Random sets: mostly small, some medium, and a few that fill the
        // table; the third random set always fills it with last_node clear on the final transaction.
        set_no = 0;
        while (node_total < 20 + RANDOM_ITEMS) begin
            quiet = (set_no >= 8 && set_no < 16);
            roll  = $urandom_range(99);
            if (set_no == 2)
                send_random_set(TB_MAX_NODES, 1'b0);
            else if (roll < 3)
                send_random_set(TB_MAX_NODES, 1'($urandom_range(1)));
            else if (roll < 15)
                send_random_set($urandom_range(40, 13), 1'b1);
            else
                send_random_set($urandom_range(12, 1), 1'b1);
            set_no++;
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (sb.owner_results_q.size() != 0)
            @(posedge clk);
        for (wait_cycles = 0; wait_cycles < DRAIN_CYCLES; wait_cycles++)
            @(posedge clk);

        $display("Run covered %0d node transactions in %0d sets: %0d with transparent nodes,",
                 node_total, sb.sets_closed, sb.transparent_sets);
        $display("%0d filling the table; checked %0d results, %0d mismatches, %0d never seen.",
                 sb.full_sets, sb.checked, sb.mismatches, sb.owner_results_q.size());
        if (sb.mismatches == 0 && sb.owner_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- transparent_owner_pass_through_core.f -----
+incdir+rtl
rtl/tpo_pkg.sv
rtl/tpo_dpath.sv
rtl/tpo_ctrl.sv
rtl/transparent_owner_pass_through_core.sv
sim/testbench.sv
